// ----- hdl/quadtree_block_uniformity_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quadtree block uniformity checker
// Both macros sample on clk_i and stay quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef QUADTREE_BLOCK_UNIFORMITY_TOP_ASSERT_SVH
`define QUADTREE_BLOCK_UNIFORMITY_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QBU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qbu check failed");

// Consequent must hold in the cycle after the antecedent.
`define QBU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qbu check failed");

`endif

// ----- hdl/qbu_pkg.sv -----
// ----------------------------------------------------------------------------
// qbu_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package qbu_pkg;

  // Image geometry. The side must be a power of two: the pixel address is
  // the row and column bits placed side by side.
  localparam int IMG_LOG2 = 8;
  localparam int IMG_SIDE = 1 << IMG_LOG2;
  localparam int ADDR_W   = 2 * IMG_LOG2;
  localparam int COORD_W  = 17;           // holds row plus a side of 2**15
  localparam int LG_W     = 4;
  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int SUM_W    = CH_W + ADDR_W;
  localparam int SQ_W     = 2 * CH_W;
  localparam int NRM_W    = SQ_W + 2;     // mean squared deviation, times three
  localparam int DEV_W    = NRM_W + ADDR_W;
  localparam int THR_W    = 16;
  localparam int SCORE_W  = 16;

  // Floor division by three through a reciprocal; exact for values below
  // two to the power RECIP_SH - 1.
  localparam int RECIP_W  = 19;
  localparam int RECIP_SH = 20;
  localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(((1 << RECIP_SH) + 2) / 3);
  localparam int PROD_W   = NRM_W + RECIP_W;

  // Input item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  typedef struct packed {
    logic wr;        // store the input pixel
    logic load;      // latch an evaluate request
    logic walk;      // issue one pixel read of the block walk
    logic dev_pass;  // reads belong to the deviation pass
    logic mean;      // latch channel means, restart the walk
    logic norm;      // divide the deviation sum by the pixel count
    logic div;       // divide by three
    logic emit;      // load the result register
  } qbu_cmd_t;

  typedef struct packed {
    logic walk_last; // the read issued now is the last one of the block
    logic busy;      // read data still in flight
    logic oor;       // latched block lies outside the image
    logic out_free;  // result register can take a new result
  } qbu_status_t;

endpackage

// ----- hdl/quadtree_block_uniformity_top.sv -----
// ----------------------------------------------------------------------------
// quadtree_block_uniformity_top
// Pixel store with block mean and uniformity score for quadtree splitting.
// ----------------------------------------------------------------------------
// The block keeps a 256 x 256 RGB image and scores square blocks of it. A
// beat with tuser = 0 writes one pixel, so the image loads at one pixel per
// clock while no evaluation runs; it never produces an output beat. A beat
// with tuser = 1 asks for a block evaluation. The block is walked twice
// through the single read port of the pixel store, one pixel per cycle: the
// first pass sums the channels, the second sums the squared deviations from
// the floored means. An evaluation checks the range, runs the sum pass,
// latches the means, runs the deviation pass, divides by the pixel count
// and by three, and loads its result once the output register is free; a
// block outside the image goes straight from the range check to loading
// its result. No input beat is taken while an evaluation runs. The result
// waits in an output register, and the input side reopens as soon as the
// result is loaded there. The threshold is written through cfg_we_i and
// cfg_wdata_i and must only change while the block is idle. Reading a pixel
// that was never written gives an undefined result.
// ----------------------------------------------------------------------------
module quadtree_block_uniformity_top
  import qbu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input beat.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // From bit 0: row[7:0], column[15:8], side_log2[19:16], red_in[27:20],
  // green_in[35:28], blue_in[43:36], zero fill [47:44].
  input  logic [47:0] s_axis_tdata,
  // Bit 0: kind (0 write pixel, 1 evaluate block).
  input  logic        s_axis_tuser,
  // Output beat.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // From bit 0: mean_red[7:0], mean_green[15:8], mean_blue[23:16],
  // score[39:24].
  output logic [39:0] m_axis_tdata,
  // From bit 0: is_leaf[0], out_of_range[1].
  output logic [1:0]  m_axis_tuser,
  // Threshold register.
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  qbu_cmd_t    cmd;
  qbu_status_t st;
  logic        is_leaf, out_of_range;

  qbu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  qbu_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .row_i          (s_axis_tdata[7:0]),
    .column_i       (s_axis_tdata[15:8]),
    .side_log2_i    (s_axis_tdata[19:16]),
    .red_in_i       (s_axis_tdata[27:20]),
    .green_in_i     (s_axis_tdata[35:28]),
    .blue_in_i      (s_axis_tdata[43:36]),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .mean_red_o     (m_axis_tdata[7:0]),
    .mean_green_o   (m_axis_tdata[15:8]),
    .mean_blue_o    (m_axis_tdata[23:16]),
    .score_o        (m_axis_tdata[39:24]),
    .is_leaf_o      (is_leaf),
    .out_of_range_o (out_of_range)
  );

  assign m_axis_tuser = {out_of_range, is_leaf};

endmodule

// ----- hdl/qbu_ctrl.sv -----
// ----------------------------------------------------------------------------
// qbu_ctrl
// Sequencer for pixel writes and the two-pass block evaluation.
// ----------------------------------------------------------------------------
module qbu_ctrl
  import qbu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_kind_i,
  output logic        in_ready_o,
  input  qbu_status_t st_i,
  output qbu_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_SUMW = 4'd3;
  localparam logic [3:0] S_MEAN = 4'd4;
  localparam logic [3:0] S_DEV  = 4'd5;
  localparam logic [3:0] S_DEVW = 4'd6;
  localparam logic [3:0] S_NORM = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept && (in_kind_i == KIND_WRITE)) begin
          cmd_o.wr = 1'b1;
        end
        if (accept && (in_kind_i == KIND_EVAL)) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        state_d = st_i.oor ? S_OUT : S_SUM;
      end
      S_SUM: begin
        cmd_o.walk = 1'b1;
        if (st_i.walk_last) begin
          state_d = S_SUMW;
        end
      end
      S_SUMW: begin
        if (!st_i.busy) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd_o.mean = 1'b1;
        state_d    = S_DEV;
      end
      S_DEV: begin
        cmd_o.walk     = 1'b1;
        cmd_o.dev_pass = 1'b1;
        if (st_i.walk_last) begin
          state_d = S_DEVW;
        end
      end
      S_DEVW: begin
        cmd_o.dev_pass = 1'b1;
        if (!st_i.busy) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/qbu_dp.sv -----
// ----------------------------------------------------------------------------
// qbu_dp
// Pixel store, block walk, channel sums, deviation sum and result register.
// ----------------------------------------------------------------------------
module qbu_dp
  import qbu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qbu_cmd_t           cmd_i,
  output qbu_status_t        st_o,
  input  logic [7:0]         row_i,
  input  logic [7:0]         column_i,
  input  logic [LG_W-1:0]    side_log2_i,
  input  logic [CH_W-1:0]    red_in_i,
  input  logic [CH_W-1:0]    green_in_i,
  input  logic [CH_W-1:0]    blue_in_i,
  input  logic               cfg_we_i,
  input  logic [THR_W-1:0]   cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CH_W-1:0]    mean_red_o,
  output logic [CH_W-1:0]    mean_green_o,
  output logic [CH_W-1:0]    mean_blue_o,
  output logic [SCORE_W-1:0] score_o,
  output logic               is_leaf_o,
  output logic               out_of_range_o
);

  logic [PIX_W-1:0]   mem [2**ADDR_W];

  logic [THR_W-1:0]   thr_q;
  logic [7:0]         row_q, col_q;
  logic [LG_W-1:0]    lg_q;
  logic               oor_q;
  logic [ADDR_W-1:0]  idx_q;
  logic               rd_vld_q, sq_vld_q;
  logic [PIX_W-1:0]   rd_data_q;
  logic [SUM_W-1:0]   sum_q [3];
  logic [CH_W-1:0]    mean_q [3];
  logic [SQ_W-1:0]    sq_q [3];
  logic [DEV_W-1:0]   dev_q;
  logic [NRM_W-1:0]   nrm_q;
  logic [SCORE_W-1:0] score_q;
  logic               out_valid_q;

  logic [COORD_W-1:0] side;
  logic               req_oor;
  logic               wr_in_img;
  logic [ADDR_W-1:0]  idx_mask;
  logic [ADDR_W-1:0]  side_mask;
  logic [ADDR_W-1:0]  roff, coff;
  logic [7:0]         rd_row, rd_col;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CH_W-1:0]    chan [3];
  logic [4:0]         shamt;
  logic [PROD_W-1:0]  prod;

  // Request decode.
  assign side    = COORD_W'(1) << side_log2_i;
  assign req_oor = ((COORD_W'(row_i) + side) > COORD_W'(IMG_SIDE)) ||
                   ((COORD_W'(column_i) + side) > COORD_W'(IMG_SIDE));
  assign wr_in_img = (COORD_W'(row_i) < COORD_W'(IMG_SIDE)) &&
                     (COORD_W'(column_i) < COORD_W'(IMG_SIDE));

  // Walk through the block in raster order.
  assign shamt     = {lg_q, 1'b0};
  assign idx_mask  = ADDR_W'(((ADDR_W + 1)'(1) << shamt) - (ADDR_W + 1)'(1));
  assign side_mask = ADDR_W'((ADDR_W'(1) << lg_q) - ADDR_W'(1));
  assign roff      = idx_q >> lg_q;
  assign coff      = idx_q & side_mask;
  assign rd_row    = row_q + roff[7:0];
  assign rd_col    = col_q + coff[7:0];
  assign rd_addr   = {rd_row[IMG_LOG2-1:0], rd_col[IMG_LOG2-1:0]};

  assign chan[0] = rd_data_q[PIX_W-1 -: CH_W];
  assign chan[1] = rd_data_q[SQ_W-1 -: CH_W];
  assign chan[2] = rd_data_q[CH_W-1:0];

  assign prod = PROD_W'(nrm_q) * PROD_W'(RECIP3);

  assign st_o.walk_last = (idx_q == idx_mask);
  assign st_o.busy      = rd_vld_q || sq_vld_q;
  assign st_o.oor       = oor_q;
  assign st_o.out_free  = !out_valid_q || out_ready_i;

  // Pixel store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_in_img) begin
      mem[{row_i[IMG_LOG2-1:0], column_i[IMG_LOG2-1:0]}] <=
        {red_in_i, green_in_i, blue_in_i};
    end
    if (cmd_i.walk) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      rd_vld_q    <= 1'b0;
      sq_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      rd_vld_q <= cmd_i.walk;
      sq_vld_q <= rd_vld_q && cmd_i.dev_pass;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q <= row_i;
      col_q <= column_i;
      lg_q  <= side_log2_i;
      oor_q <= req_oor;
      idx_q <= '0;
      dev_q <= '0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
    end
    if (cmd_i.walk) begin
      idx_q <= idx_q + ADDR_W'(1);
    end
    // Sum pass.
    if (rd_vld_q && !cmd_i.dev_pass) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= sum_q[k] + SUM_W'(chan[k]);
      end
    end
    if (cmd_i.mean) begin
      idx_q <= '0;
      for (int k = 0; k < 3; k++) begin
        mean_q[k] <= CH_W'(sum_q[k] >> shamt);
      end
    end
    // Deviation pass: square stage, then accumulate.
    if (rd_vld_q && cmd_i.dev_pass) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= (chan[k] >= mean_q[k]) ?
                   SQ_W'(chan[k] - mean_q[k]) * SQ_W'(chan[k] - mean_q[k]) :
                   SQ_W'(mean_q[k] - chan[k]) * SQ_W'(mean_q[k] - chan[k]);
      end
    end
    if (sq_vld_q) begin
      dev_q <= dev_q + DEV_W'(sq_q[0]) + DEV_W'(sq_q[1]) + DEV_W'(sq_q[2]);
    end
    if (cmd_i.norm) begin
      nrm_q <= NRM_W'(dev_q >> shamt);
    end
    if (cmd_i.div) begin
      score_q <= SCORE_W'(prod >> RECIP_SH);
    end
    if (cmd_i.emit) begin
      mean_red_o     <= oor_q ? '0 : mean_q[0];
      mean_green_o   <= oor_q ? '0 : mean_q[1];
      mean_blue_o    <= oor_q ? '0 : mean_q[2];
      score_o        <= oor_q ? '0 : score_q;
      is_leaf_o      <= !oor_q && (score_q <= thr_q);
      out_of_range_o <= oor_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/qbu_checker.sv -----
// ----------------------------------------------------------------------------
// qbu_checker
// Port-level checks of result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "quadtree_block_uniformity_top_assert.svh"

module qbu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        cfg_we_i,
  input logic [15:0] cfg_wdata_i
);

  logic [15:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // A stalled result beat keeps its contents.
  `QBU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // A block outside the image reports nothing else.
  `QBU_ASSERT_SAME(a_oor_zero, m_axis_tvalid && m_axis_tuser[1], (m_axis_tdata == '0) && !m_axis_tuser[0])

  // The leaf flag agrees with the score and the programmed threshold.
  `QBU_ASSERT_SAME(a_leaf, m_axis_tvalid && !m_axis_tuser[1], m_axis_tuser[0] == (m_axis_tdata[39:24] <= thr_q))

  // The score never exceeds the largest possible squared deviation.
  `QBU_ASSERT_SAME(a_score_max, m_axis_tvalid, m_axis_tdata[39:24] <= 16'd65025)

  // Input data that the checks do not look at.
  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ s_axis_tuser;

endmodule

bind quadtree_block_uniformity_top qbu_checker u_qbu_checker (.*);
